FILE: src/video_chip_ports_and_line_timing_unit_macros.svh
// assertion helpers for the port and line timing unit
`ifndef VIDEO_CHIP_PORTS_AND_LINE_TIMING_UNIT_MACROS_SVH
`define VIDEO_CHIP_PORTS_AND_LINE_TIMING_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define VCP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define VCP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/vcp_pkg.sv
package vcp_pkg;

    localparam int VRAM_BYTES    = 16384;
    localparam int VRAM_AW       = $clog2(VRAM_BYTES);
    localparam int PAL_DEPTH     = 64;
    localparam int PAL_AW        = $clog2(PAL_DEPTH);
    localparam int VISIBLE_LINES = 192;
    localparam int LINE_W        = 9;

    // frame geometry and v-counter jump points
    localparam int FRAME_LINES_PAL  = 313;
    localparam int FRAME_LINES_NTSC = 262;
    localparam int VC_PAL_TOP       = 'hF2;
    localparam int VC_PAL_JUMP      = 57;
    localparam int VC_NTSC_TOP      = 'hDA;
    localparam int VC_NTSC_JUMP     = 6;

    // request kinds
    localparam logic [2:0] KIND_CTRL = 3'd0;
    localparam logic [2:0] KIND_DWR  = 3'd1;
    localparam logic [2:0] KIND_DRD  = 3'd2;
    localparam logic [2:0] KIND_STAT = 3'd3;
    localparam logic [2:0] KIND_TICK = 3'd4;

    // operation codes from the second control byte
    localparam logic [1:0] OP_VRAM_RD = 2'd0;
    localparam logic [1:0] OP_VRAM_WR = 2'd1;
    localparam logic [1:0] OP_REG_WR  = 2'd2;
    localparam logic [1:0] OP_PAL_WR  = 2'd3;

    // mode register indexes and enable bits
    localparam logic [3:0] REG_MODE0       = 4'd0;
    localparam logic [3:0] REG_MODE1       = 4'd1;
    localparam logic [3:0] REG_LINE_RELOAD = 4'd10;
    localparam int MODE0_LINE_IE_BIT = 4;
    localparam int MODE1_VBL_IE_BIT  = 5;

    // configuration register indexes
    localparam logic CFG_HANDHELD = 1'b0;
    localparam logic CFG_PAL      = 1'b1;

    typedef struct packed {
        logic               en;
        logic               we;
        logic [VRAM_AW-1:0] addr;
        logic [7:0]         wdata;
    } vram_req_t;

    typedef struct packed {
        logic              we;
        logic [PAL_AW-1:0] addr;
        logic [7:0]        wdata;
    } pal_req_t;

    typedef struct packed {
        logic       tick;
        logic       clear_flags;
        logic       pal_region;
        logic [7:0] reload;
    } timing_ctl_t;

    typedef struct packed {
        logic       vblank;
        logic       line_irq;
        logic [7:0] v_count;
        logic       wrap;
    } timing_stat_t;

endpackage

FILE: src/video_chip_ports_and_line_timing_unit.sv
// CPU port side and line timing of a tile video chip. Each request on the
// s_ stream (control write, data write, data read, status read, line tick)
// gives exactly one result on the m_ stream with the read byte, the
// interrupt level and the v-counter as they stand after it, and m_tlast set
// when a line tick wrapped the frame. For each request the accept cycle
// updates the port registers and issues the single video memory access,
// and the next cycle lands the synchronous read data in the read buffer,
// commits the second byte of a word palette write and forms the result.
// A finished result waits in the output register, and one more request may
// be taken and finished behind it. After reset the video memory is zeroed
// by a clearing pass, one byte a cycle, and no request is accepted until
// it ends; configuration writes are taken at any time.
`include "video_chip_ports_and_line_timing_unit_macros.svh"

module video_chip_ports_and_line_timing_unit
    import vcp_pkg::*;
#(
    parameter int VIS_LINES = VISIBLE_LINES
)
(
    input  logic        clk,
    input  logic        rst_n,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // value[7:0]
    input  logic [2:0]  s_tuser,   // kind[2:0]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // read_value[7:0], irq_level[8], v_count[16:9], zero pad
    output logic        m_tlast,   // frame_end
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic        cfg_data
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;

    typedef struct packed {
        logic       frame_end;
        logic [7:0] v_count;
        logic       irq;
        logic [7:0] read_value;
    } result_t;

    logic [1:0]         state_reg, state_next;
    logic [VRAM_AW-1:0] addr_reg, addr_next;
    logic [1:0]         op_reg, op_next;
    logic [7:0]         rbuf_reg, rbuf_next;
    logic               pend_reg, pend_next;
    logic [7:0]         first_reg, first_next;
    logic [7:0]         latch_reg, latch_next;
    logic [7:0]         mode_reg [16];
    logic [7:0]         mode_next [16];
    logic               handheld_reg, handheld_next;
    logic               pal_reg, pal_next;
    logic               prefetch_reg, prefetch_next;
    logic               pal2_reg, pal2_next;
    logic [PAL_AW-1:0]  pal2_addr_reg, pal2_addr_next;
    logic [7:0]         pal2_data_reg, pal2_data_next;
    logic [7:0]         item_rv_reg, item_rv_next;
    logic               item_fe_reg, item_fe_next;
    logic               res_valid_reg, res_valid_next;
    result_t            res_reg, res_next;
    logic               m_tvalid_reg, m_tvalid_next;
    result_t            out_reg, out_next;

    vram_req_t          vram_req;
    logic [7:0]         vram_rdata;
    logic               vram_busy;
    pal_req_t           pal_req;
    logic               pal_busy;
    timing_ctl_t        tctl;
    timing_stat_t       tstat;

    logic               accept;
    logic [VRAM_AW-1:0] addr_ctl;
    logic [VRAM_AW-1:0] addr_inc;
    result_t            exec_res;
    logic               out_free;

    vcp_vram u_vram (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (vram_req),
        .rdata (vram_rdata),
        .busy  (vram_busy)
    );

    vcp_palette u_palette (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (pal_req),
        .busy  (pal_busy)
    );

    vcp_timing #(
        .VIS_LINES (VIS_LINES)
    ) u_timing (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (tctl),
        .stat  (tstat)
    );

    // one request in flight; a second may finish behind a waiting result
    assign s_tready  = (state_reg == ST_IDLE) && !res_valid_reg;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // address from the second control byte and the first one held back
    assign addr_ctl = {s_tdata[5:0], first_reg};
    assign addr_inc = addr_reg + 1'b1;

    always_comb
    begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        op_next        = op_reg;
        rbuf_next      = rbuf_reg;
        pend_next      = pend_reg;
        first_next     = first_reg;
        latch_next     = latch_reg;
        mode_next      = mode_reg;
        handheld_next  = handheld_reg;
        pal_next       = pal_reg;
        prefetch_next  = 1'b0;
        pal2_next      = 1'b0;
        pal2_addr_next = pal2_addr_reg;
        pal2_data_next = pal2_data_reg;
        item_rv_next   = item_rv_reg;
        item_fe_next   = item_fe_reg;

        vram_req       = '0;
        pal_req        = '0;
        tctl.tick        = 1'b0;
        tctl.clear_flags = 1'b0;
        tctl.pal_region  = pal_reg;
        tctl.reload      = mode_reg[REG_LINE_RELOAD];

        // configuration registers
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_HANDHELD: handheld_next = cfg_data;
                CFG_PAL:      pal_next      = cfg_data;
            endcase
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                if (!vram_busy && !pal_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next   = ST_EXEC;
                    item_rv_next = 8'h00;
                    item_fe_next = 1'b0;
                    unique case (s_tuser)
                        KIND_CTRL:
                        begin
                            if (!pend_reg)
                            begin
                                // first byte: low address bits at once
                                first_next = s_tdata;
                                addr_next  = {addr_reg[VRAM_AW-1:8], s_tdata};
                                pend_next  = 1'b1;
                            end
                            else
                            begin
                                pend_next = 1'b0;
                                op_next   = s_tdata[7:6];
                                addr_next = addr_ctl;
                                if (s_tdata[7:6] == OP_VRAM_RD)
                                begin
                                    // read setup prefetches into the buffer
                                    vram_req.en   = 1'b1;
                                    vram_req.addr = addr_ctl;
                                    addr_next     = addr_ctl + 1'b1;
                                    prefetch_next = 1'b1;
                                end
                                else if (s_tdata[7:6] == OP_REG_WR)
                                begin
                                    mode_next[s_tdata[3:0]] = first_reg;
                                end
                            end
                        end
                        KIND_DWR:
                        begin
                            pend_next = 1'b0;
                            if (op_reg == OP_PAL_WR)
                            begin
                                if (handheld_reg)
                                begin
                                    if (addr_reg[0])
                                    begin
                                        // odd byte commits the latched even byte first
                                        pal_req.we     = 1'b1;
                                        pal_req.addr   = {addr_reg[PAL_AW-1:1], 1'b0};
                                        pal_req.wdata  = latch_reg;
                                        pal2_next      = 1'b1;
                                        pal2_addr_next = addr_reg[PAL_AW-1:0];
                                        pal2_data_next = s_tdata;
                                    end
                                    else
                                    begin
                                        latch_next = s_tdata;
                                    end
                                end
                                else
                                begin
                                    pal_req.we    = 1'b1;
                                    pal_req.addr  = {1'b0, addr_reg[PAL_AW-2:0]};
                                    pal_req.wdata = s_tdata;
                                end
                            end
                            else
                            begin
                                vram_req.en    = 1'b1;
                                vram_req.we    = 1'b1;
                                vram_req.addr  = addr_reg;
                                vram_req.wdata = s_tdata;
                            end
                            rbuf_next = s_tdata;
                            addr_next = addr_inc;
                        end
                        KIND_DRD:
                        begin
                            item_rv_next  = rbuf_reg;
                            pend_next     = 1'b0;
                            vram_req.en   = 1'b1;
                            vram_req.addr = addr_reg;
                            prefetch_next = 1'b1;
                            addr_next     = addr_inc;
                        end
                        KIND_STAT:
                        begin
                            item_rv_next     = {tstat.vblank, 7'b0};
                            pend_next        = 1'b0;
                            tctl.clear_flags = 1'b1;
                        end
                        KIND_TICK:
                        begin
                            tctl.tick    = 1'b1;
                            item_fe_next = tstat.wrap;
                        end
                        default:
                        begin
                            // unused kinds change nothing
                        end
                    endcase
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
                if (prefetch_reg)
                begin
                    rbuf_next = vram_rdata;
                end
                if (pal2_reg)
                begin
                    pal_req.we    = 1'b1;
                    pal_req.addr  = pal2_addr_reg;
                    pal_req.wdata = pal2_data_reg;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result as the state stands after the request
    always_comb
    begin
        exec_res.read_value = item_rv_reg;
        exec_res.irq        = (tstat.vblank && mode_reg[REG_MODE1][MODE1_VBL_IE_BIT]) ||
                              (tstat.line_irq && mode_reg[REG_MODE0][MODE0_LINE_IE_BIT]);
        exec_res.v_count    = tstat.v_count;
        exec_res.frame_end  = item_fe_reg;
    end

    // output register with one pending slot behind it
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        m_tvalid_next  = m_tvalid_reg;
        out_next       = out_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        if (out_free)
        begin
            if (res_valid_reg)
            begin
                m_tvalid_next  = 1'b1;
                out_next       = res_reg;
                res_valid_next = 1'b0;
            end
            else if (state_reg == ST_EXEC)
            begin
                m_tvalid_next = 1'b1;
                out_next      = exec_res;
            end
            else
            begin
                m_tvalid_next = 1'b0;
            end
        end
        else if (state_reg == ST_EXEC)
        begin
            res_valid_next = 1'b1;
            res_next       = exec_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            addr_reg      <= '0;
            op_reg        <= OP_VRAM_RD;
            rbuf_reg      <= 8'h00;
            pend_reg      <= 1'b0;
            first_reg     <= 8'h00;
            latch_reg     <= 8'h00;
            mode_reg      <= '{default: 8'h00};
            handheld_reg  <= 1'b0;
            pal_reg       <= 1'b0;
            prefetch_reg  <= 1'b0;
            pal2_reg      <= 1'b0;
            pal2_addr_reg <= '0;
            pal2_data_reg <= 8'h00;
            item_rv_reg   <= 8'h00;
            item_fe_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
            m_tvalid_reg  <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            op_reg        <= op_next;
            rbuf_reg      <= rbuf_next;
            pend_reg      <= pend_next;
            first_reg     <= first_next;
            latch_reg     <= latch_next;
            mode_reg      <= mode_next;
            handheld_reg  <= handheld_next;
            pal_reg       <= pal_next;
            prefetch_reg  <= prefetch_next;
            pal2_reg      <= pal2_next;
            pal2_addr_reg <= pal2_addr_next;
            pal2_data_reg <= pal2_data_next;
            item_rv_reg   <= item_rv_next;
            item_fe_reg   <= item_fe_next;
            res_valid_reg <= res_valid_next;
            res_reg       <= res_next;
            m_tvalid_reg  <= m_tvalid_next;
            out_reg       <= out_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'b0, out_reg.v_count, out_reg.irq, out_reg.read_value};
    assign m_tlast  = out_reg.frame_end;

    // a pending result only exists while the output register is full
    `VCP_ASSERT_IMPL(a_res_behind_out, clk, rst_n, res_valid_reg, m_tvalid_reg, "pending result with empty output")
    // no port access reaches video memory during the clearing pass
    `VCP_ASSERT_IMPL(a_no_vram_in_clear, clk, rst_n, vram_busy, !vram_req.en, "video memory request during clear")
    // an accepted request always gets its finishing cycle next
    `VCP_ASSERT_NEXT(a_accept_to_exec, clk, rst_n, s_tvalid && s_tready, state_reg == ST_EXEC, "accepted request not finished")
    // buffer fill and second palette byte only land in the finishing cycle
    `VCP_ASSERT_IMPL(a_late_work_in_exec, clk, rst_n, prefetch_reg || pal2_reg, state_reg == ST_EXEC, "late work outside finishing cycle")

endmodule

FILE: src/vcp_vram.sv
module vcp_vram
    import vcp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  vram_req_t  req,
    output logic [7:0] rdata,
    output logic       busy
);

    logic [7:0]         mem [VRAM_BYTES];
    logic [VRAM_AW-1:0] clr_addr_reg, clr_addr_next;
    logic               busy_reg, busy_next;
    logic [7:0]         rdata_reg;
    logic               wr_en;
    logic [VRAM_AW-1:0] wr_addr;
    logic [7:0]         wr_data;

    // zero sweep after reset, one byte a cycle
    always_comb
    begin
        clr_addr_next = clr_addr_reg;
        busy_next     = busy_reg;
        if (busy_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == {VRAM_AW{1'b1}})
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            busy_reg     <= 1'b1;
        end
        else
        begin
            clr_addr_reg <= clr_addr_next;
            busy_reg     <= busy_next;
        end
    end

    assign wr_en   = busy_reg || (req.en && req.we);
    assign wr_addr = busy_reg ? clr_addr_reg : req.addr;
    assign wr_data = busy_reg ? 8'h00 : req.wdata;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (req.en && !req.we)
        begin
            rdata_reg <= mem[req.addr];
        end
    end

    assign rdata = rdata_reg;
    assign busy  = busy_reg;

endmodule

FILE: src/vcp_palette.sv
module vcp_palette
    import vcp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  pal_req_t req,
    output logic     busy
);

    // write side only; the renderer owns the read side
    logic [7:0]        mem [PAL_DEPTH];
    logic [PAL_AW-1:0] clr_addr_reg, clr_addr_next;
    logic              busy_reg, busy_next;

    always_comb
    begin
        clr_addr_next = clr_addr_reg;
        busy_next     = busy_reg;
        if (busy_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == {PAL_AW{1'b1}})
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            busy_reg     <= 1'b1;
        end
        else
        begin
            clr_addr_reg <= clr_addr_next;
            busy_reg     <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            mem[clr_addr_reg] <= 8'h00;
        end
        else if (req.we)
        begin
            mem[req.addr] <= req.wdata;
        end
    end

    assign busy = busy_reg;

endmodule

FILE: src/vcp_timing.sv
module vcp_timing
    import vcp_pkg::*;
#(
    parameter int VIS_LINES = VISIBLE_LINES
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  timing_ctl_t  ctl,
    output timing_stat_t stat
);

    logic [LINE_W-1:0] line_reg, line_next;
    logic [7:0]        cnt_reg, cnt_next;
    logic              vblank_reg, vblank_next;
    logic              lirq_reg, lirq_next;
    logic [LINE_W-1:0] frame_lines;
    logic [LINE_W-1:0] line_inc;
    logic              wrap;
    logic [LINE_W-1:0] vc_sub;
    logic [7:0]        v_count;

    assign frame_lines = ctl.pal_region ? LINE_W'(FRAME_LINES_PAL) : LINE_W'(FRAME_LINES_NTSC);
    assign line_inc    = line_reg + 1'b1;
    assign wrap        = (line_inc >= frame_lines);

    always_comb
    begin
        line_next   = line_reg;
        cnt_next    = cnt_reg;
        vblank_next = vblank_reg;
        lirq_next   = lirq_reg;
        if (ctl.tick)
        begin
            if (line_reg == LINE_W'(VIS_LINES))
            begin
                vblank_next = 1'b1;
            end
            if (line_reg <= LINE_W'(VIS_LINES))
            begin
                if (cnt_reg == 8'h00)
                begin
                    cnt_next  = ctl.reload;
                    lirq_next = 1'b1;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            else
            begin
                cnt_next = ctl.reload;
            end
            line_next = wrap ? '0 : line_inc;
        end
        if (ctl.clear_flags)
        begin
            vblank_next = 1'b0;
            lirq_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_reg   <= '0;
            cnt_reg    <= 8'hFF;
            vblank_reg <= 1'b0;
            lirq_reg   <= 1'b0;
        end
        else
        begin
            line_reg   <= line_next;
            cnt_reg    <= cnt_next;
            vblank_reg <= vblank_next;
            lirq_reg   <= lirq_next;
        end
    end

    // region-specific jump of the v-counter
    always_comb
    begin
        if (ctl.pal_region)
        begin
            vc_sub  = line_reg - LINE_W'(VC_PAL_JUMP);
            v_count = (line_reg <= LINE_W'(VC_PAL_TOP)) ? line_reg[7:0] : vc_sub[7:0];
        end
        else
        begin
            vc_sub  = line_reg - LINE_W'(VC_NTSC_JUMP);
            v_count = (line_reg <= LINE_W'(VC_NTSC_TOP)) ? line_reg[7:0] : vc_sub[7:0];
        end
    end

    assign stat.vblank   = vblank_reg;
    assign stat.line_irq = lirq_reg;
    assign stat.v_count  = v_count;
    assign stat.wrap     = wrap;

endmodule
